[rtl/core/fbp_pkg.sv]
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared widths, types and constants of the first-fit bin packer.
// ----------------------------------------------------------------------------
package fbp_pkg;

    localparam int LOAD_W      = 16;
    localparam int ID_W        = 16;
    localparam int BIN_IDX_W   = 6;
    localparam int BINS_USED_W = 7;

    typedef logic [LOAD_W-1:0] t_load;

    localparam t_load CAP_RESET = 16'hFFFF;

endpackage

[rtl/core/fbp_load_ram.sv]
// ----------------------------------------------------------------------------
// fbp_load_ram
// Bin load memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module fbp_load_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  fbp_pkg::t_load  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output fbp_pkg::t_load  o_rdata
);
    import fbp_pkg::*;

    t_load r_mem [DEPTH];
    t_load r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/first_fit_bin_packer.sv]
// ----------------------------------------------------------------------------
// first_fit_bin_packer
// Online first-fit bin packing over a memory of bin loads.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. The open bin loads are then
// read from the load memory one per cycle, in bin order, and each is compared
// in the cycle after its read, so the scan length is set by the single read
// port of that memory; the S_PUSH state then hands the result to the output
// register once it is free, and that register holds it while the next item is taken. The
// load memory needs no clearing after reset or at the end of an instance,
// because an entry is only read after its bin has been opened and written.
module first_fit_bin_packer #(
    parameter int MAX_BINS    = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbp_pkg::LOAD_W-1:0]        i_cfg_data,
    // Input item channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fbp_pkg::ID_W-1:0]          i_item_id,
    input  logic [fbp_pkg::LOAD_W-1:0]        i_weight,
    input  logic                              i_last_item,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fbp_pkg::ID_W-1:0]          o_placed_item,
    output logic [fbp_pkg::BIN_IDX_W-1:0]     o_bin_index,
    output logic [fbp_pkg::BINS_USED_W-1:0]   o_bins_used,
    output logic                              o_new_bin,
    output logic                              o_oversize,
    output logic                              o_overflow,
    output logic                              o_instance_done
);
    import fbp_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);
    localparam logic [LOAD_W-1:0] WMASK =
        LOAD_W'((33'd1 << WEIGHT_BITS) - 33'd1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_load             r_cap;
    logic [CW-1:0]     r_open, n_open;
    logic [CW-1:0]     r_rd_ptr, n_rd_ptr;
    logic              r_cmp_valid, n_cmp_valid;
    logic [AW-1:0]     r_cmp_ptr;
    t_load             r_w;
    logic [ID_W-1:0]   r_id;
    logic              r_last;
    logic              r_big;

    // Result waiting for the output register.
    logic [BIN_IDX_W-1:0]   r_res_idx, n_res_idx;
    logic [BINS_USED_W-1:0] r_res_used, n_res_used;
    logic                   r_res_new, n_res_new;
    logic                   r_res_ovf, n_res_ovf;

    logic                   r_out_valid;
    logic [ID_W-1:0]        r_out_id;
    logic [BIN_IDX_W-1:0]   r_out_idx;
    logic [BINS_USED_W-1:0] r_out_used;
    logic                   r_out_new;
    logic                   r_out_big;
    logic                   r_out_ovf;
    logic                   r_out_last;

    logic                   in_acc;
    logic                   out_free;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    t_load                  ram_wdata;
    logic                   ram_re;
    t_load                  ram_rdata;
    logic [LOAD_W:0]        sum;
    logic                   fits;
    logic [31:0]            idx_full;
    logic [31:0]            used_full;
    t_load                  w_in;

    fbp_load_ram #(
        .DEPTH (MAX_BINS)
    ) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign w_in        = i_weight & WMASK;

    assign sum  = {1'b0, ram_rdata} + {1'b0, r_w};
    assign fits = r_cmp_valid && (sum <= {1'b0, r_cap});

    always_comb begin
        n_state     = r_state;
        n_open      = r_open;
        n_rd_ptr    = r_rd_ptr;
        n_cmp_valid = 1'b0;
        n_res_idx   = r_res_idx;
        n_res_used  = r_res_used;
        n_res_new   = r_res_new;
        n_res_ovf   = r_res_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_cmp_ptr;
        ram_wdata   = sum[LOAD_W-1:0];
        ram_re      = 1'b0;
        idx_full    = 32'(r_cmp_ptr);
        used_full   = 32'(r_open);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rd_ptr = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads run one bin ahead of the compare.
                ram_re      = (r_rd_ptr < r_open);
                n_cmp_valid = ram_re;
                if (ram_re) begin
                    n_rd_ptr = r_rd_ptr + 1'b1;
                end
                if (fits) begin
                    ram_we    = 1'b1;
                    n_res_idx = idx_full[BIN_IDX_W-1:0];
                    n_res_new = 1'b0;
                    n_res_ovf = 1'b0;
                    n_open    = r_last ? '0 : r_open;
                    n_res_used = used_full[BINS_USED_W-1:0];
                    n_state   = S_PUSH;
                end else if (!ram_re) begin
                    // Every open bin has been compared and none fits.
                    if (r_open < MAX_CNT) begin
                        ram_we     = 1'b1;
                        ram_waddr  = r_open[AW-1:0];
                        ram_wdata  = r_w;
                        idx_full   = 32'(r_open);
                        used_full  = 32'(r_open + 1'b1);
                        n_res_idx  = idx_full[BIN_IDX_W-1:0];
                        n_res_new  = 1'b1;
                        n_res_ovf  = 1'b0;
                        n_res_used = used_full[BINS_USED_W-1:0];
                        n_open     = r_last ? '0 : CW'(r_open + 1'b1);
                    end else begin
                        n_res_idx  = '0;
                        n_res_new  = 1'b0;
                        n_res_ovf  = 1'b1;
                        n_res_used = used_full[BINS_USED_W-1:0];
                        n_open     = r_last ? '0 : r_open;
                    end
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_open      <= '0;
            r_rd_ptr    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_rd_ptr    <= n_rd_ptr;
            r_cmp_valid <= n_cmp_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_ptr  <= r_rd_ptr[AW-1:0];
        r_res_idx  <= n_res_idx;
        r_res_used <= n_res_used;
        r_res_new  <= n_res_new;
        r_res_ovf  <= n_res_ovf;
        if (in_acc) begin
            r_id   <= i_item_id;
            r_w    <= w_in;
            r_last <= i_last_item;
            r_big  <= (w_in > r_cap);
        end
        if (r_state == S_PUSH && out_free) begin
            r_out_id   <= r_id;
            r_out_idx  <= r_res_idx;
            r_out_used <= r_res_used;
            r_out_new  <= r_res_new;
            r_out_big  <= r_big;
            r_out_ovf  <= r_res_ovf;
            r_out_last <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_placed_item   = r_out_id;
    assign o_bin_index     = r_out_idx;
    assign o_bins_used     = r_out_used;
    assign o_new_bin       = r_out_new;
    assign o_oversize      = r_out_big;
    assign o_overflow      = r_out_ovf;
    assign o_instance_done = r_out_last;

endmodule
